// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the density converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ODFV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ODFV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ODFV_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ODFV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/odfv_pkg.sv =====
// Shared constants, status codes and the log2 interpolation table.
`timescale 1ns / 1ps
package odfv_pkg;

  localparam int LOG_TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES);
  localparam int VAL_W = 20;
  localparam int FRAC_W = VAL_W - 1;
  localparam int REM_W = FRAC_W - IDX_W;
  localparam int ENTRY_W = 25;
  localparam int LOG_W = 29;
  localparam int MSB_W = 5;

  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913987;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [1:0] REG_REF = 2'd0;
  localparam logic [1:0] REG_AMAX = 2'd1;
  localparam logic [1:0] REG_CELLS = 2'd2;
  localparam logic [1:0] REG_FEED = 2'd3;

  typedef logic [ENTRY_W-1:0] rom_t [LOG_TABLE_ENTRIES+1];

  function automatic rom_t build_rom();
    rom_t r;
    logic [63:0] x;
    logic [23:0] y;
    for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
      if (i == LOG_TABLE_ENTRIES) begin
        r[i] = ENTRY_W'(1) << 24;
      end else begin
        x = ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / 64'(LOG_TABLE_ENTRIES);
        y = '0;
        for (int b = 0; b < 24; b++) begin
          x = (x * x) >> 30;
          y = {y[22:0], 1'b0};
          if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            y[0] = 1'b1;
          end
        end
        r[i] = ENTRY_W'(y);
      end
    end
    return r;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

endpackage

// ===== rtl/optical_density_to_feed_volume.sv =====
// Pipelined optical density, cell concentration and feed volume converter.
//
//  channel  direction  handshake                 words
//  in       input      in_valid_i / in_stall_o    intensity_i
//  out      output     out_valid_o / out_stall_i  status_o, optical_density_o,
//                                                 concentration_o, feed_volume_o
//  cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One word enters per cycle unless the pipeline is stalled and passes 38 register
// stages: two three-stage log units in series, six arithmetic stages, a divider load
// stage, a 24-stage restoring divider that produces one quotient bit per stage,
// and the output register.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module optical_density_to_feed_volume (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] intensity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [18:0] optical_density_o,
  output logic [31:0] concentration_o,
  output logic [23:0] feed_volume_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import odfv_pkg::*;

  localparam int DIV_N = 24;
  localparam int FL = 3;

  typedef struct packed {
    logic [1:0]  status;
    logic [18:0] od;
    logic [31:0] conc;
    logic        sat;
    logic [31:0] rem;
    logic [23:0] num_lo;
    logic [23:0] q;
  } div_t;

  logic [19:0] ref_q;
  logic [15:0] amax_q;
  logic [23:0] cells_q;
  logic [31:0] feed_q;

  logic adv;

  logic             f_valid_q [FL];
  logic             f_bad_q [FL];
  logic [LOG_W-1:0] la1, lb1, la2, lb2;
  logic [LOG_W-1:0] l1, m2;
  logic             in_bad;

  logic        p1_valid_q, p1_bad_q;
  logic [60:0] p1_prod_q;
  logic [60:0] od_sum;
  logic [18:0] od_calc;
  logic [18:0] a_ext;

  logic        p2_valid_q;
  logic [1:0]  p2_status_q;
  logic [18:0] p2_od_q;
  logic [17:0] p2_a_q, p2_d_q;

  logic        m_valid_q [FL];
  logic [1:0]  m_status_q [FL];
  logic [18:0] m_od_q [FL];

  logic        p3_valid_q;
  logic [1:0]  p3_status_q;
  logic [18:0] p3_od_q;
  logic [60:0] p3_prod_q;
  logic [60:0] ln_sum;

  logic        p4_valid_q;
  logic [1:0]  p4_status_q;
  logic [18:0] p4_od_q;
  logic [LOG_W-1:0] p4_lnq_q;

  logic        p5_valid_q;
  logic [1:0]  p5_status_q;
  logic [18:0] p5_od_q;
  logic [52:0] p5_prod_q;
  logic [52:0] c_sum;

  logic        p6_valid_q;
  logic [1:0]  p6_status_q;
  logic [18:0] p6_od_q;
  logic [31:0] p6_conc_q;
  logic [40:0] num;

  logic dv_valid_q [DIV_N+1];
  div_t dv_q [DIV_N+1];
  div_t dv_d [DIV_N];

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [18:0] od_q;
  logic [31:0] conc_q;
  logic [23:0] vol_q;

  assign adv = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  assign in_bad = (intensity_i == '0) || (ref_q == '0) || (intensity_i > ref_q);

  odfv_log2 u_log_ref (.clk_i(clk_i), .en_i(adv), .val_i(ref_q), .log_o(la1));
  odfv_log2 u_log_in (.clk_i(clk_i), .en_i(adv), .val_i(intensity_i), .log_o(lb1));
  odfv_log2 u_log_a (.clk_i(clk_i), .en_i(adv), .val_i({2'b0, p2_a_q}), .log_o(la2));
  odfv_log2 u_log_d (.clk_i(clk_i), .en_i(adv), .val_i({2'b0, p2_d_q}), .log_o(lb2));

  assign l1 = (la1 > lb1) ? (la1 - lb1) : '0;
  assign m2 = (la2 > lb2) ? (la2 - lb2) : '0;

  assign od_sum = p1_prod_q + (61'd1 << 39);
  assign od_calc = od_sum[58:40];
  assign a_ext = {1'b0, amax_q, 2'b00};

  assign ln_sum = p3_prod_q + (61'd1 << 31);
  assign c_sum = p5_prod_q + (53'd1 << 23);

  assign num = {1'b0, feed_q, 8'b0} + 41'(p6_conc_q[31:1]);

  always_comb begin
    for (int k = 0; k < DIV_N; k++) begin
      logic [32:0] trial;
      trial = {dv_q[k].rem, dv_q[k].num_lo[23]};
      dv_d[k] = dv_q[k];
      dv_d[k].num_lo = {dv_q[k].num_lo[22:0], 1'b0};
      if (trial >= {1'b0, dv_q[k].conc}) begin
        dv_d[k].rem = 32'(trial - {1'b0, dv_q[k].conc});
        dv_d[k].q = {dv_q[k].q[22:0], 1'b1};
      end else begin
        dv_d[k].rem = trial[31:0];
        dv_d[k].q = {dv_q[k].q[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= 20'd752742;
      amax_q  <= 16'd20644;
      cells_q <= 24'd265957;
      feed_q  <= 32'd9260500;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REF:   ref_q <= cfg_data_i[19:0];
        REG_AMAX:  amax_q <= cfg_data_i[15:0];
        REG_CELLS: cells_q <= cfg_data_i[23:0];
        REG_FEED:  feed_q <= cfg_data_i;
        default:   ref_q <= ref_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FL; k++) begin
        f_valid_q[k] <= 1'b0;
        m_valid_q[k] <= 1'b0;
      end
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
      p5_valid_q <= 1'b0;
      p6_valid_q <= 1'b0;
      for (int k = 0; k <= DIV_N; k++) begin
        dv_valid_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      f_valid_q[0] <= in_valid_i;
      m_valid_q[0] <= p2_valid_q;
      for (int k = 1; k < FL; k++) begin
        f_valid_q[k] <= f_valid_q[k-1];
        m_valid_q[k] <= m_valid_q[k-1];
      end
      p1_valid_q <= f_valid_q[FL-1];
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= m_valid_q[FL-1];
      p4_valid_q <= p3_valid_q;
      p5_valid_q <= p4_valid_q;
      p6_valid_q <= p5_valid_q;
      dv_valid_q[0] <= p6_valid_q;
      for (int k = 1; k <= DIV_N; k++) begin
        dv_valid_q[k] <= dv_valid_q[k-1];
      end
      out_valid_q <= dv_valid_q[DIV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_bad_q[0] <= in_bad;
      for (int k = 1; k < FL; k++) begin
        f_bad_q[k] <= f_bad_q[k-1];
      end

      p1_bad_q  <= f_bad_q[FL-1];
      p1_prod_q <= 61'(l1) * 61'(LOG10_2_Q32);

      if (p1_bad_q) begin
        p2_status_q <= ST_RANGE;
        p2_od_q     <= '0;
      end else begin
        p2_status_q <= (od_calc >= a_ext) ? ST_SAT : ST_OK;
        p2_od_q     <= od_calc;
      end
      p2_a_q <= a_ext[17:0];
      p2_d_q <= 18'(a_ext - od_calc);

      m_status_q[0] <= p2_status_q;
      m_od_q[0]     <= p2_od_q;
      for (int k = 1; k < FL; k++) begin
        m_status_q[k] <= m_status_q[k-1];
        m_od_q[k]     <= m_od_q[k-1];
      end

      p3_status_q <= m_status_q[FL-1];
      p3_od_q     <= m_od_q[FL-1];
      p3_prod_q   <= 61'(m2) * 61'(LN2_Q32);

      p4_status_q <= p3_status_q;
      p4_od_q     <= p3_od_q;
      p4_lnq_q    <= ln_sum[LOG_W+31:32];

      p5_status_q <= p4_status_q;
      p5_od_q     <= p4_od_q;
      p5_prod_q   <= 53'(p4_lnq_q) * 53'(cells_q);

      p6_status_q <= p5_status_q;
      p6_od_q     <= p5_od_q;
      p6_conc_q   <= (p5_status_q == ST_OK) ? 32'(c_sum[52:24]) : '0;

      dv_q[0].status <= p6_status_q;
      dv_q[0].od     <= p6_od_q;
      dv_q[0].conc   <= p6_conc_q;
      dv_q[0].sat    <= (32'(num[40:24]) >= p6_conc_q);
      dv_q[0].rem    <= 32'(num[40:24]);
      dv_q[0].num_lo <= num[23:0];
      dv_q[0].q      <= '0;
      for (int k = 1; k <= DIV_N; k++) begin
        dv_q[k] <= dv_d[k-1];
      end

      status_q <= dv_q[DIV_N].status;
      od_q     <= dv_q[DIV_N].od;
      conc_q   <= dv_q[DIV_N].conc;
      if (dv_q[DIV_N].conc == '0) begin
        vol_q <= '0;
      end else if (dv_q[DIV_N].sat) begin
        vol_q <= '1;
      end else begin
        vol_q <= dv_q[DIV_N].q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign optical_density_o = od_q;
  assign concentration_o = conc_q;
  assign feed_volume_o = vol_q;

  `ODFV_ASSERT_IMPL(a_bad_zero, clk_i, rst_ni,
                    out_valid_o && (status_o != ST_OK),
                    (concentration_o == '0) && (feed_volume_o == '0))
  `ODFV_ASSERT_IMPL(a_range_od, clk_i, rst_ni,
                    out_valid_o && (status_o == ST_RANGE), optical_density_o == '0)
  `ODFV_ASSERT_IMPL(a_conc_vol, clk_i, rst_ni,
                    out_valid_o && (concentration_o == '0), feed_volume_o == '0)
  `ODFV_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni,
                    in_stall_o, out_valid_o && $stable(feed_volume_o))

endmodule

// ===== rtl/odfv_log2.sv =====
// Three-stage pipelined base-2 logarithm with table interpolation, Q24 result.
`timescale 1ns / 1ps
module odfv_log2 (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [odfv_pkg::VAL_W-1:0] val_i,
  output logic [odfv_pkg::LOG_W-1:0] log_o
);
  import odfv_pkg::*;

  logic [MSB_W-1:0]   msb;
  logic [VAL_W-1:0]   norm;
  logic [MSB_W-1:0]   p_q;
  logic [IDX_W-1:0]   idx_q;
  logic [REM_W-1:0]   rem_q;
  logic [ENTRY_W-1:0] lo;
  logic [ENTRY_W-1:0] hi;
  logic [ENTRY_W-1:0] diff;
  logic [ENTRY_W+REM_W-1:0] prod;
  logic [LOG_W-1:0]   base_q;
  logic [ENTRY_W-1:0] frac_q;
  logic [LOG_W-1:0]   log_q;

  always_comb begin
    msb = '0;
    for (int k = 0; k < VAL_W; k++) begin
      if (val_i[k]) begin
        msb = MSB_W'(k);
      end
    end
    norm = val_i << (MSB_W'(VAL_W - 1) - msb);
  end

  assign lo = LOG_ROM[idx_q];
  assign hi = LOG_ROM[{1'b0, idx_q} + (IDX_W + 1)'(1)];
  assign diff = hi - lo;
  assign prod = (ENTRY_W + REM_W)'(diff) * (ENTRY_W + REM_W)'(rem_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= msb;
      idx_q  <= norm[FRAC_W-1 -: IDX_W];
      rem_q  <= norm[REM_W-1:0];
      base_q <= (LOG_W'(p_q) << 24) + LOG_W'(lo);
      frac_q <= prod[ENTRY_W+REM_W-1:REM_W];
      log_q  <= base_q + LOG_W'(frac_q);
    end
  end

  assign log_o = log_q;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the optical density to feed volume converter.
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0]  status;
  logic [18:0] density;
  logic [31:0] conc;
  logic [23:0] volume;
} density_result_t;

class density_scoreboard;
  logic [19:0] ref_level;
  logic [15:0] amax;
  logic [23:0] cells_per_unit;
  logic [31:0] feed_cells;
  longint unsigned log_table [odfv_pkg::LOG_TABLE_ENTRIES+1];
  density_result_t pending [$];
  int errors;
  int taken;
  int checked;

  function new();
    longint unsigned x;
    longint unsigned y;
    longint unsigned n;
    n = odfv_pkg::LOG_TABLE_ENTRIES;
    for (int i = 0; i <= odfv_pkg::LOG_TABLE_ENTRIES; i++) begin
      if (i == odfv_pkg::LOG_TABLE_ENTRIES) begin
        log_table[i] = 64'd1 << 24;
      end else begin
        x = ((n + i) << 30) / n;
        y = 0;
        for (int b = 0; b < 24; b++) begin
          x = (x * x) >> 30;
          y = y << 1;
          if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            y = y | 1;
          end
        end
        log_table[i] = y;
      end
    end
    ref_level = 20'd752742;
    amax = 16'd20644;
    cells_per_unit = 24'd265957;
    feed_cells = 32'd9260500;
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] val);
    case (idx)
      odfv_pkg::REG_REF: ref_level = val[19:0];
      odfv_pkg::REG_AMAX: amax = val[15:0];
      odfv_pkg::REG_CELLS: cells_per_unit = val[23:0];
      odfv_pkg::REG_FEED: feed_cells = val;
      default: ;
    endcase
  endfunction

  function longint unsigned log2_fixed(longint unsigned v);
    longint unsigned p;
    longint unsigned f;
    longint unsigned t;
    longint unsigned idx;
    longint unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned diff;
    v = v & 64'hFFFF_FFFF;
    if (v == 0) return 0;
    p = 0;
    while ((v >> p) > 1) p++;
    f = (v << (31 - p)) & 64'h7FFF_FFFF;
    t = f * odfv_pkg::LOG_TABLE_ENTRIES;
    idx = t >> 31;
    rem = t & 64'h7FFF_FFFF;
    lo = log_table[idx];
    hi = (idx + 1 > odfv_pkg::LOG_TABLE_ENTRIES) ? log_table[odfv_pkg::LOG_TABLE_ENTRIES]
                                                 : log_table[idx + 1];
    diff = (hi > lo) ? hi - lo : 0;
    return (p << 24) + lo + ((diff * rem) >> 31);
  endfunction

  function density_result_t predict_result(logic [19:0] level);
    density_result_t r;
    longint unsigned la;
    longint unsigned lb;
    longint unsigned l;
    longint unsigned od;
    longint unsigned a;
    longint unsigned m;
    longint unsigned lnq;
    longint unsigned c;
    longint unsigned vol;
    r = '0;
    if (level == 0 || ref_level == 0 || level > ref_level) begin
      r.status = odfv_pkg::ST_RANGE;
      return r;
    end
    la = log2_fixed(ref_level);
    lb = log2_fixed(level);
    l = (la > lb) ? la - lb : 0;
    od = ((l * 64'd1292913987 + (64'd1 << 39)) >> 40) & 64'h7FFFF;
    r.density = od[18:0];
    a = 64'(amax) << 2;
    if (od >= a) begin
      r.status = odfv_pkg::ST_SAT;
      return r;
    end
    la = log2_fixed(a);
    lb = log2_fixed(a - od);
    m = (la > lb) ? la - lb : 0;
    lnq = (m * 64'd2977044472 + (64'd1 << 31)) >> 32;
    c = (lnq * cells_per_unit + (64'd1 << 23)) >> 24;
    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
    r.status = odfv_pkg::ST_OK;
    r.conc = c[31:0];
    if (c != 0) begin
      vol = ((64'(feed_cells) << 8) + (c >> 1)) / c;
      if (vol > 64'hFF_FFFF) vol = 64'hFF_FFFF;
      r.volume = vol[23:0];
    end
    return r;
  endfunction

  task report(string what);
    errors++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  function void note_sample(logic [19:0] level);
    pending.push_back(predict_result(level));
    taken++;
  endfunction

  task check_result(density_result_t got);
    density_result_t want;
    checked++;
    if (pending.size() == 0) begin
      report("result word with no sample pending");
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.density !== want.density)
      report($sformatf("density %0d, expected %0d", got.density, want.density));
    if (got.conc !== want.conc)
      report($sformatf("concentration %0d, expected %0d", got.conc, want.conc));
    if (got.volume !== want.volume)
      report($sformatf("volume %0d, expected %0d", got.volume, want.volume));
  endtask
endclass

module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [19:0] intensity_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [18:0] optical_density_o;
  logic [31:0] concentration_o;
  logic [23:0] feed_volume_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  int send_idle_pct;
  int recv_idle_pct;
  density_scoreboard sb;

  optical_density_to_feed_volume dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(intensity_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({status_o, optical_density_o, concentration_o, feed_volume_o});
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_word(logic [19:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    intensity_i <= level;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic [19:0] pick_level(logic [19:0] lvl_ref);
    int sel;
    int w;
    logic [19:0] v;
    sel = $urandom_range(99);
    w = $urandom_range(20, 1);
    v = 20'($urandom & ((32'd1 << w) - 32'd1));
    if (sel < 6) return 20'd0;
    if (sel < 16) return 20'($urandom);
    if (sel < 22 && lvl_ref != 20'hFFFFF) return lvl_ref + 20'd1 + 20'($urandom_range(3));
    if (sel < 32 && lvl_ref > 8) return lvl_ref - 20'($urandom_range(8));
    if (lvl_ref == 0) return v;
    if (v == 0) v = 20'd1;
    if (v > lvl_ref) v = (v % lvl_ref) + 20'd1;
    return v;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_word(pick_level(sb.ref_level));
    drain();
  endtask

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(20'd0);
    send_word(20'd1);
    send_word(20'd752742);
    send_word(20'd752743);
    send_word(20'hFFFFF);
    send_word(20'd376371);
    send_word(20'd500000);
    send_word(20'd700000);
    send_word(20'h80000);
    send_word(20'h7FFFF);
    drain();
    write_reg(odfv_pkg::REG_CELLS, 32'd1);
    send_word(20'd752741);
    send_word(20'd752700);
    drain();
    write_reg(odfv_pkg::REG_REF, 32'd0);
    send_word(20'd5);
    send_word(20'hFFFFF);
    drain();
    write_reg(odfv_pkg::REG_REF, 32'hFFFFF);
    write_reg(odfv_pkg::REG_AMAX, 32'd65535);
    write_reg(odfv_pkg::REG_CELLS, 32'hFFFFFF);
    write_reg(odfv_pkg::REG_FEED, 32'hFFFF_FFFF);
    send_word(20'hFFFFF);
    send_word(20'hFFFFE);
    send_word(20'd1);
    send_word(20'd1000);
    send_word(20'd300000);
    drain();
    write_reg(odfv_pkg::REG_AMAX, 32'd1);
    write_reg(odfv_pkg::REG_FEED, 32'd0);
    send_word(20'hFFFFF);
    send_word(20'hFFFF0);
    send_word(20'd2);
    drain();

    send_idle_pct = 18;
    recv_idle_pct = 59;
    write_reg(odfv_pkg::REG_REF, 32'd752742);
    write_reg(odfv_pkg::REG_AMAX, 32'd20644);
    write_reg(odfv_pkg::REG_CELLS, 32'd265957);
    write_reg(odfv_pkg::REG_FEED, 32'd9260500);
    random_phase(200);
    write_reg(odfv_pkg::REG_REF, $urandom);
    write_reg(odfv_pkg::REG_AMAX, $urandom_range(65535, 1));
    write_reg(odfv_pkg::REG_CELLS, $urandom_range(24'hFFFFFF, 1));
    write_reg(odfv_pkg::REG_FEED, $urandom);
    random_phase(150);

    send_idle_pct = 59;
    recv_idle_pct = 18;
    write_reg(odfv_pkg::REG_REF, 32'hFFFFF);
    write_reg(odfv_pkg::REG_AMAX, 32'd65535);
    write_reg(odfv_pkg::REG_CELLS, 32'hFFFFFF);
    write_reg(odfv_pkg::REG_FEED, 32'hFFFF_FFFF);
    random_phase(175);
    write_reg(odfv_pkg::REG_REF, 32'd4000);
    write_reg(odfv_pkg::REG_AMAX, 32'd1);
    write_reg(odfv_pkg::REG_CELLS, 32'd1);
    write_reg(odfv_pkg::REG_FEED, 32'd0);
    random_phase(175);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(odfv_pkg::REG_REF, 32'd0);
    random_phase(30);
    write_reg(odfv_pkg::REG_REF, $urandom);
    write_reg(odfv_pkg::REG_AMAX, $urandom_range(65535, 1));
    write_reg(odfv_pkg::REG_CELLS, $urandom_range(24'hFFFFFF, 1));
    write_reg(odfv_pkg::REG_FEED, $urandom);
    random_phase(300);

    repeat (40) @(posedge clk_i);
    $display("Run covered %0d samples and %0d results over several register settings,",
             sb.taken, sb.checked);
    $display("including range errors, saturation, zero concentration and both idle mixes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/odfv_pkg.sv
rtl/odfv_log2.sv
rtl/optical_density_to_feed_volume.sv
bench/tb.sv
